// ----- rtl/core/hct_pkg.sv -----
// hct_pkg: shared types and constants of the hashed command table.
// Holds the port payload structs, the queue entry, the back-end state enum and the FNV-1a step.
// No dependencies.
package hct_pkg;

  localparam int unsigned HASH_W      = 32;
  localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;
  localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;
  localparam logic [15:0] BAD_CLUSTER = 16'hFFFF;
  localparam logic [7:0]  BAD_COMMAND = 8'hFF;

  typedef enum logic [1:0] {
    MODE_INSERT   = 2'd0,
    MODE_RETRIEVE = 2'd1,
    MODE_REMOVE   = 2'd2,
    MODE_UNUSED   = 2'd3
  } hct_mode_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  key_byte;
    logic        key_last;
    logic [15:0] cluster_in;
    logic [7:0]  command_in;
  } hct_in_t;

  typedef struct packed {
    logic        status;
    logic [15:0] cluster_out;
    logic [7:0]  command_out;
  } hct_out_t;

  typedef struct packed {
    logic [HASH_W-1:0] hash;
    logic [1:0]        mode;
    logic [15:0]       cluster;
    logic [7:0]        command;
  } hct_job_t;

  typedef struct packed {
    logic [15:0] cluster;
    logic [7:0]  command;
  } hct_slot_t;

  typedef struct packed {
    logic     push;
    hct_job_t job;
  } hct_push_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_DIV,
    B_ACCESS,
    B_RESP
  } hct_bstate_t;

  function automatic logic [HASH_W-1:0] fnv_mix(input logic [HASH_W-1:0] h,
                                                input logic [7:0] b);
    logic [HASH_W-1:0] x;
    x = h ^ {{(HASH_W-8){1'b0}}, b};
    return x * FNV_PRIME;
  endfunction

endpackage

// ----- rtl/core/hashed_command_table.sv -----
// hashed_command_table: FNV-1a keyed direct-mapped command table, top level.
// Key bytes transfer at one per cycle while busy is low; the back end takes a finished key from
// the queue when idle and strobes its result after the access state, preceded, unless
// TABLE_ENTRIES is a power of two, by the reciprocal-multiply remainder steps LO, HI, SUB, FIX.
// A two-entry queue holds finished keys; busy rises while it is full. The receiver cannot stall.
// After reset, busy stays high while every slot of the memory is cleared.
// Depends on hct_pkg, hct_front, hct_queue, hct_back.
module hashed_command_table #(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned KEY_BYTES     = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  hct_pkg::hct_in_t  in_data,
  output logic              out_strobe,
  output hct_pkg::hct_out_t out_data
);
  import hct_pkg::*;

  hct_push_t push;
  hct_job_t  head;
  logic      empty, full, pop, clearing, accept;

  assign busy   = clearing | full;
  assign accept = start & ~busy;

  hct_front #(
    .KEY_BYTES(KEY_BYTES)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .in_data(in_data),
    .push_o (push)
  );

  hct_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push_i(push),
    .pop   (pop),
    .head  (head),
    .empty (empty),
    .full  (full)
  );

  hct_back #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .clearing  (clearing),
    .out_strobe(out_strobe),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/core/hct_front.sv -----
// hct_front: accepts key bytes, folds up to KEY_BYTES of them into the FNV-1a hash,
// and pushes one job per key into the queue on the last byte.
// Depends on hct_pkg.
module hct_front #(
  parameter int unsigned KEY_BYTES = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  hct_pkg::hct_in_t   in_data,
  output hct_pkg::hct_push_t push_o
);
  import hct_pkg::*;

  localparam int unsigned BW = $clog2(KEY_BYTES + 1);

  logic [HASH_W-1:0] hash_r, hash_nxt, mixed;
  logic [BW-1:0]     cnt_r, cnt_nxt;
  logic              take;

  always_comb begin
    take     = cnt_r < BW'(KEY_BYTES);
    mixed    = take ? fnv_mix(hash_r, in_data.key_byte) : hash_r;
    hash_nxt = hash_r;
    cnt_nxt  = cnt_r;
    if (accept) begin
      if (in_data.key_last) begin
        hash_nxt = FNV_BASIS;
        cnt_nxt  = '0;
      end else begin
        hash_nxt = mixed;
        cnt_nxt  = take ? cnt_r + BW'(1) : cnt_r;
      end
    end
  end

  always_comb begin
    push_o.push        = accept & in_data.key_last;
    push_o.job.hash    = mixed;
    push_o.job.mode    = in_data.mode;
    push_o.job.cluster = in_data.cluster_in;
    push_o.job.command = in_data.command_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= FNV_BASIS;
      cnt_r  <= '0;
    end else begin
      hash_r <= hash_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/core/hct_queue.sv -----
// hct_queue: two-entry job queue between the hashing front and the table back end.
// Depends on hct_pkg.
module hct_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  hct_pkg::hct_push_t push_i,
  input  logic               pop,
  output hct_pkg::hct_job_t  head,
  output logic               empty,
  output logic               full
);
  import hct_pkg::*;

  hct_job_t   ent_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign empty   = cnt_r == 2'd0;
  assign full    = cnt_r == 2'd2;
  assign head    = ent_r[rd_ptr_r];
  assign do_push = push_i.push & ~full;
  assign do_pop  = pop & ~empty;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_i.job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/core/hct_back.sv -----
// hct_back: clears the slot memory after reset, reduces each job's hash to a slot (reciprocal
// multiply in steps LO, HI, SUB, FIX unless the table size is a power of two), runs the operation.
// Depends on hct_pkg.
module hct_back #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  hct_pkg::hct_job_t head,
  input  logic              empty,
  output logic              pop,
  output logic              clearing,
  output logic              out_strobe,
  output hct_pkg::hct_out_t out_data
);
  import hct_pkg::*;

  localparam int unsigned SW   = $clog2(TABLE_ENTRIES);
  localparam int unsigned RW   = SW + 1;
  localparam bit          POW2 = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;
  localparam int unsigned PW   = 2 * HASH_W + 1;
  localparam int unsigned LO_W = 17;
  localparam int unsigned HI_W = HASH_W + 1 - LO_W;
  localparam logic [PW-1:0]   RECIP    = (PW'(1) << (HASH_W + SW)) / PW'(TABLE_ENTRIES);
  localparam logic [LO_W-1:0] RECIP_LO = RECIP[LO_W-1:0];
  localparam logic [HI_W-1:0] RECIP_HI = RECIP[HASH_W:LO_W];
  localparam logic [1:0] STEP_LO  = 2'd0;
  localparam logic [1:0] STEP_HI  = 2'd1;
  localparam logic [1:0] STEP_SUB = 2'd2;
  localparam logic [1:0] STEP_FIX = 2'd3;

  hct_slot_t mem [TABLE_ENTRIES];

  hct_bstate_t         state_r, state_nxt;
  hct_job_t            job_r;
  logic [1:0]          step_r;
  logic [PW-1:0]       acc_r;
  logic [HASH_W-1:0]   part_r;
  logic [SW-1:0]       rem_r, clr_r;
  logic [SW-1:0]       cnt_r;
  logic                status_r;
  hct_slot_t           rd_r;

  logic [HASH_W+LO_W-1:0] prod_lo;
  logic [HASH_W+HI_W-1:0] prod_hi;
  logic [HASH_W-1:0]   quo, quo_n;
  logic                ins_ok, mem_we;
  logic [SW-1:0]       mem_addr;
  hct_slot_t           mem_wdata;

  always_comb begin
    prod_lo = (HASH_W+LO_W)'(job_r.hash) * (HASH_W+LO_W)'(RECIP_LO);
    prod_hi = (HASH_W+HI_W)'(job_r.hash) * (HASH_W+HI_W)'(RECIP_HI);
    quo     = HASH_W'(acc_r >> (HASH_W + SW));
    quo_n   = quo * HASH_W'(TABLE_ENTRIES);
    ins_ok  = (job_r.cluster != BAD_CLUSTER) && (job_r.command != BAD_COMMAND) &&
              (({1'b0, cnt_r} + RW'(1)) < RW'(TABLE_ENTRIES));
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_CLEAR: begin
        if (clr_r == SW'(TABLE_ENTRIES - 1)) state_nxt = B_IDLE;
      end
      B_IDLE: begin
        if (!empty) state_nxt = POW2 ? B_ACCESS : B_DIV;
      end
      B_DIV: begin
        if (step_r == STEP_FIX) state_nxt = B_ACCESS;
      end
      B_ACCESS: state_nxt = B_RESP;
      B_RESP:   state_nxt = B_IDLE;
      default:  state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    pop        = 1'b0;
    clearing   = 1'b0;
    out_strobe = 1'b0;
    mem_we     = 1'b0;
    mem_addr   = rem_r;
    mem_wdata  = '0;
    out_data   = '0;
    unique case (state_r)
      B_CLEAR: begin
        clearing  = 1'b1;
        mem_we    = 1'b1;
        mem_addr  = clr_r;
        mem_wdata = '{cluster: BAD_CLUSTER, command: BAD_COMMAND};
      end
      B_IDLE: pop = ~empty;
      B_DIV: ;
      B_ACCESS: begin
        if (job_r.mode == MODE_INSERT) begin
          mem_we    = ins_ok;
          mem_wdata = '{cluster: job_r.cluster, command: job_r.command};
        end else if (job_r.mode == MODE_REMOVE) begin
          mem_we = 1'b1;
        end
      end
      B_RESP: begin
        out_strobe      = 1'b1;
        out_data.status = status_r;
        if (job_r.mode == MODE_RETRIEVE) begin
          out_data.cluster_out = rd_r.cluster;
          out_data.command_out = rd_r.command;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_r <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (state_r == B_IDLE && !empty) begin
      job_r  <= head;
      step_r <= STEP_LO;
      rem_r  <= POW2 ? head.hash[SW-1:0] : '0;
    end else if (state_r == B_DIV) begin
      step_r <= step_r + 2'd1;
      case (step_r)
        STEP_LO:  acc_r  <= PW'(prod_lo);
        STEP_HI:  acc_r  <= acc_r + (PW'(prod_hi) << LO_W);
        STEP_SUB: part_r <= job_r.hash - quo_n;
        default: begin
          rem_r <= (part_r >= HASH_W'(TABLE_ENTRIES)) ?
                   SW'(part_r - HASH_W'(TABLE_ENTRIES)) : SW'(part_r);
        end
      endcase
    end
    if (state_r == B_ACCESS) begin
      case (job_r.mode)
        MODE_INSERT:                status_r <= ~ins_ok;
        MODE_RETRIEVE, MODE_REMOVE: status_r <= 1'b0;
        default:                    status_r <= 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_CLEAR;
      clr_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_CLEAR) clr_r <= clr_r + SW'(1);
      if (state_r == B_ACCESS && job_r.mode == MODE_INSERT && ins_ok) begin
        cnt_r <= cnt_r + SW'(1);
      end
    end
  end

endmodule

// ----- test/hashed_command_table_tb.sv -----
// hashed_command_table_tb: self-checking bench for the FNV-1a keyed command table.
// Drives key bytes from a queue, predicts each per-key result, checks every strobed result.
// Depends on hct_pkg and hashed_command_table.
module hashed_command_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hct_pkg::*;

  localparam int unsigned TABLE_ENTRIES = 64;
  localparam int unsigned KEY_BYTES     = 32;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned DRAIN_CYCLES  = 60;
  localparam int unsigned PHASE_BYTES   = 225;
  localparam int unsigned REPORT_LIMIT  = 10;

  typedef enum logic [1:0] {
    KEY_POOL,
    KEY_RANDOM,
    KEY_FIXED
  } key_src_t;

  logic     clk     = 1'b0;
  logic     rst_n   = 1'b0;
  logic     start   = 1'b0;
  logic     busy;
  hct_in_t  in_data = '0;
  logic     out_strobe;
  hct_out_t out_data;

  hashed_command_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .KEY_BYTES    (KEY_BYTES)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  hct_in_t     pending_bytes[$];
  hct_out_t    expected_results[$];
  hct_out_t    want_result;
  int unsigned idle_pct      = 0;
  int unsigned error_count   = 0;
  int unsigned bytes_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned full_rejects  = 0;
  int unsigned cycle_count   = 0;

  // predictor state
  logic [31:0] hash_acc;
  int unsigned bytes_mixed;
  int unsigned insert_count;
  logic [15:0] slot_cluster [TABLE_ENTRIES];
  logic [7:0]  slot_command [TABLE_ENTRIES];

  task automatic clear_table();
    hash_acc     = FNV_BASIS;
    bytes_mixed  = 0;
    insert_count = 0;
    for (int unsigned i = 0; i < TABLE_ENTRIES; i++) begin
      slot_cluster[i] = BAD_CLUSTER;
      slot_command[i] = BAD_COMMAND;
    end
  endtask

  // mix one accepted byte; on the last byte run the operation and queue its result
  task automatic mix_key_byte(input hct_in_t item);
    int unsigned slot;
    hct_out_t    res;
    if (bytes_mixed < KEY_BYTES) begin
      hash_acc    = (hash_acc ^ {24'd0, item.key_byte}) * FNV_PRIME;
      bytes_mixed = bytes_mixed + 1;
    end
    if (item.key_last) begin
      slot       = hash_acc % TABLE_ENTRIES;
      res        = '0;
      res.status = 1'b1;
      case (hct_mode_t'(item.mode))
        MODE_INSERT: begin
          if (item.cluster_in != BAD_CLUSTER && item.command_in != BAD_COMMAND) begin
            if (insert_count + 1 < TABLE_ENTRIES) begin
              slot_cluster[slot] = item.cluster_in;
              slot_command[slot] = item.command_in;
              insert_count       = insert_count + 1;
              res.status         = 1'b0;
            end else begin
              full_rejects = full_rejects + 1;
            end
          end
        end
        MODE_RETRIEVE: begin
          res.cluster_out = slot_cluster[slot];
          res.command_out = slot_command[slot];
          res.status      = 1'b0;
        end
        MODE_REMOVE: begin
          slot_cluster[slot] = 16'd0;
          slot_command[slot] = 8'd0;
          res.status         = 1'b0;
        end
        default: ;
      endcase
      hash_acc    = FNV_BASIS;
      bytes_mixed = 0;
      expected_results.push_back(res);
    end
  endtask

  task automatic note_error(input string msg);
    error_count = error_count + 1;
    if (error_count <= REPORT_LIMIT) $display("%s", msg);
  endtask

  // long pool keys (id 100 and up) share their first KEY_BYTES bytes
  function automatic logic [7:0] pool_byte(input int unsigned id, input int unsigned pos);
    int unsigned base;
    base = (id >= 100 && pos < KEY_BYTES) ? 100 : id;
    return 8'((base * 29 + pos * 83 + base * pos * 7 + 90) % 256);
  endfunction

  function automatic int unsigned pool_len(input int unsigned id);
    return (id >= 100) ? KEY_BYTES + 1 + (id - 100) : 1 + (id * 5) % 7;
  endfunction

  task automatic queue_key(input key_src_t src, input int unsigned id, input int unsigned len,
                           input logic [7:0] fill, input hct_mode_t op,
                           input logic [15:0] cl, input logic [7:0] cm);
    hct_in_t     item;
    int unsigned pos;
    for (pos = 0; pos < len; pos++) begin
      item.mode       = 2'($urandom_range(3));
      item.key_last   = 1'b0;
      item.cluster_in = 16'($urandom_range(16'hFFFF));
      item.command_in = 8'($urandom_range(8'hFF));
      case (src)
        KEY_POOL:   item.key_byte = pool_byte(id, pos);
        KEY_RANDOM: item.key_byte = 8'($urandom_range(8'hFF));
        default:    item.key_byte = fill;
      endcase
      if (pos == len - 1) begin
        item.mode       = op;
        item.key_last   = 1'b1;
        item.cluster_in = cl;
        item.command_in = cm;
      end
      pending_bytes.push_back(item);
    end
  endtask

  // mostly keys from a small pool so retrieves and removes hit earlier inserts
  task automatic queue_random_keys(input int unsigned n_bytes);
    int unsigned queued;
    int unsigned id;
    int unsigned len;
    int unsigned pick;
    key_src_t    src;
    hct_mode_t   op;
    logic [15:0] cl;
    logic [7:0]  cm;
    queued = 0;
    while (queued < n_bytes) begin
      pick = $urandom_range(99);
      if (pick < 4) begin
        src = KEY_POOL;
        id  = 100 + $urandom_range(3);
      end else if (pick < 85) begin
        src = KEY_POOL;
        id  = $urandom_range(19);
      end else begin
        src = KEY_RANDOM;
        id  = 0;
      end
      len  = (src == KEY_POOL) ? pool_len(id) : 1 + $urandom_range(5);
      pick = $urandom_range(99);
      if (pick < 40)      op = MODE_INSERT;
      else if (pick < 72) op = MODE_RETRIEVE;
      else if (pick < 90) op = MODE_REMOVE;
      else                op = MODE_UNUSED;
      cl = ($urandom_range(9) == 0) ? BAD_CLUSTER : 16'($urandom_range(16'hFFFF));
      cm = ($urandom_range(9) == 0) ? BAD_COMMAND : 8'($urandom_range(8'hFF));
      queue_key(src, id, len, 8'd0, op, cl, cm);
      queued = queued + len;
    end
  endtask

  // driver: hold until the transfer, then present the next byte or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      start   <= 1'b0;
      in_data <= '0;
    end else if (!start || !busy) begin
      if (start) begin
        mix_key_byte(in_data);
        bytes_sent = bytes_sent + 1;
      end
      if (pending_bytes.size() != 0 && $urandom_range(99) >= idle_pct) begin
        start   <= 1'b1;
        in_data <= pending_bytes.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      results_seen = results_seen + 1;
      if (expected_results.size() == 0) begin
        note_error($sformatf("unexpected result: status %0d cluster %h command %h",
                             out_data.status, out_data.cluster_out, out_data.command_out));
      end else begin
        want_result = expected_results.pop_front();
        if (out_data.status !== want_result.status ||
            out_data.cluster_out !== want_result.cluster_out ||
            out_data.command_out !== want_result.command_out) begin
          note_error($sformatf(
            "result %0d mismatch: expected %0d/%h/%h, got %0d/%h/%h", results_seen,
            want_result.status, want_result.cluster_out, want_result.command_out,
            out_data.status, out_data.cluster_out, out_data.command_out));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int unsigned phase_idle [4];
    phase_idle = '{0, 81, 20, 0};
    clear_table();

    // reset contents, valid and invalid inserts, extremes, remove, unused mode
    queue_key(KEY_FIXED, 0, 1, 8'h00, MODE_RETRIEVE, 16'd0, 8'd0);
    queue_key(KEY_FIXED, 0, 1, 8'hFF, MODE_INSERT, 16'h0000, 8'h00);
    queue_key(KEY_FIXED, 0, 1, 8'hFF, MODE_RETRIEVE, 16'd0, 8'd0);
    queue_key(KEY_FIXED, 0, 1, 8'hFF, MODE_INSERT, BAD_CLUSTER, 8'h01);
    queue_key(KEY_FIXED, 0, 1, 8'hFF, MODE_INSERT, 16'h0001, BAD_COMMAND);
    queue_key(KEY_FIXED, 0, 1, 8'h01, MODE_INSERT, 16'hFFFE, 8'hFE);
    queue_key(KEY_FIXED, 0, 1, 8'h01, MODE_RETRIEVE, 16'd0, 8'd0);
    queue_key(KEY_FIXED, 0, 1, 8'h01, MODE_REMOVE, 16'hFFFF, 8'hFF);
    queue_key(KEY_FIXED, 0, 1, 8'h01, MODE_RETRIEVE, 16'd0, 8'd0);
    queue_key(KEY_FIXED, 0, 1, 8'h80, MODE_UNUSED, 16'h1234, 8'h56);
    // zero bytes inside a key
    queue_key(KEY_FIXED, 0, 3, 8'h00, MODE_INSERT, 16'hA5A5, 8'h5A);
    queue_key(KEY_FIXED, 0, 3, 8'h00, MODE_RETRIEVE, 16'd0, 8'd0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    for (int unsigned phase = 0; phase < 4; phase++) begin
      idle_pct = phase_idle[phase];
      queue_random_keys(PHASE_BYTES);
      while (pending_bytes.size() != 0 || start) @(posedge clk);
      @(negedge clk);
    end

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d key bytes and checked %0d results across 4 idle phases.",
             bytes_sent, results_seen);
    $display("Table took %0d inserts, %0d inserts refused with the count full.",
             insert_count, full_rejects);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d errors", error_count);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
